@@ design/chte_pkg.sv @@
// Shared types, codes and helper functions for the chained hash table engine.
`timescale 1ns / 1ps
`default_nettype none
package chte_pkg;

	localparam int BUCKETS_DEF = 64;
	localparam int NODES_DEF   = 256;
	localparam int KEY_BYTES   = 8;
	localparam int VALUE_BYTES = 8;
	localparam int HASH_W      = 28;

	typedef logic [1:0] req_t;
	localparam req_t REQ_ADD    = 2'd0;
	localparam req_t REQ_GET    = 2'd1;
	localparam req_t REQ_REMOVE = 2'd2;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_NOTFOUND = 2'd1;
	localparam status_t ST_FULL     = 2'd2;

	localparam logic CFG_BUCKET_COUNT = 1'b0;
	localparam logic CFG_CAPACITY     = 1'b1;

	// Keeps the top nbytes bytes up to the first zero byte.
	function automatic logic [63:0] trim_bytes(input logic [63:0] x, input int nbytes);
		logic [63:0] r;
		logic        alive;
		r = '0;
		alive = 1'b1;
		for (int i = 0; i < 8; i++) begin
			if (x[63-8*i -: 8] == 8'd0 || i >= nbytes) alive = 1'b0;
			if (alive) r[63-8*i -: 8] = x[63-8*i -: 8];
		end
		return r;
	endfunction

	// Node count in use for a requested capacity.
	function automatic int cap_clamp(input logic [8:0] cap, input int nodes);
		int c;
		c = int'(cap);
		if (c < 1) c = 1;
		if (c > nodes) c = nodes;
		return c;
	endfunction

	// Bucket count in use for a requested count and the node count in use.
	function automatic int bkt_clamp(input logic [6:0] bc, input int cap_used,
		input int buckets);
		int b;
		b = int'(bc);
		if (b < 1) b = 1;
		if (b > cap_used) b = cap_used;
		if (b > buckets) b = buckets;
		return b;
	endfunction

endpackage
`default_nettype wire

@@ design/chained_hash_table_engine.sv @@
// Top level of the chained hash table engine: request sequencer and node memories.
//
// Channel   Direction  Handshake                 Payload
// request   in         start high, busy low      req_type, key, value
// result    out        done strobe, one cycle    status, value_out, free_count
// config    in         cfg_valid and cfg_ready   cfg_index, cfg_data
//
// One request is served at a time. On an empty chain the hash unit first takes the key
// byte by byte up to and including the first zero byte (eight at most), then runs a
// serial remainder over the 28 hash bits; the sequencer then takes the bucket, reads
// the chain head, ends the walk and acts. Each chain node compared adds a node memory
// read and a compare, and a hit skips the end of the walk. An add of a new key or a get
// hit adds state S_ALLOC or S_GETW, a remove of a present key S_REM1 and S_REM2. Reset
// is asynchronous and active low; it restores the default registers and an empty
// table. The result strobe cannot be stalled, and a configuration transfer is accepted
// whenever no request is busy.
`timescale 1ns / 1ps
`default_nettype none
module chained_hash_table_engine import chte_pkg::*; #(
	parameter int BUCKETS = BUCKETS_DEF,
	parameter int NODES   = NODES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  req_type,
	input  wire logic [63:0] key,
	input  wire logic [63:0] value,
	output logic             done,
	output logic [1:0]       status,
	output logic [63:0]      value_out,
	output logic [8:0]       free_count,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [8:0]  cfg_data
);

	// Node indexes carry one extra code, the null link, equal to NODES.
	localparam int NW = $clog2(NODES + 1);
	localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam logic [NW-1:0] NIL = NW'(NODES);

	typedef enum logic [3:0] {
		S_IDLE, S_HASH, S_HEAD, S_HEADW, S_WALK, S_CMP, S_ACT, S_ALLOC, S_GETW,
		S_REM1, S_REM2
	} state_t;

	// Configuration registers and the derived in-use sizes.
	logic [6:0]    bucket_count_q;
	logic [8:0]    capacity_q;
	logic [NW-1:0] cap_used;
	logic [6:0]    bkt_used;
	logic [8:0]    cap_wr;
	logic          cfg_we;

	// Request context.
	state_t        state_q;
	req_t          type_q;
	logic [63:0]   key_q;
	logic [63:0]   val_q;
	logic [BW-1:0] bucket_q;
	logic [NW-1:0] node_q;
	logic [NW-1:0] prev_q;
	logic [NW-1:0] head_q;
	logic [NW-1:0] link_q;
	logic [NW-1:0] steps_q;
	logic          found_q;
	logic [NW-1:0] free_head_q;
	logic [NW-1:0] free_total_q;
	logic          done_q;
	status_t       status_q;
	logic [63:0]   value_out_q;

	// Hash unit.
	logic          hash_start;
	logic          hash_done;
	logic [6:0]    hash_bucket;

	// Memories, their valid bits and registered read ports.
	logic [NW-1:0] head_mem [BUCKETS];
	logic [63:0]   key_mem  [NODES];
	logic [63:0]   val_mem  [NODES];
	logic [NW-1:0] link_mem [NODES];
	logic [BUCKETS-1:0] head_vld_q;
	logic [NODES-1:0]   link_vld_q;

	logic [NW-1:0] head_rd_s1;
	logic          head_vld_s1;
	logic [63:0]   key_rd_s1;
	logic [63:0]   val_rd_s1;
	logic [NW-1:0] link_rd_s1;
	logic          link_vld_s1;
	logic [AW-1:0] node_raddr_s1;

	logic [NW-1:0] head_rd;
	logic [NW-1:0] link_rd;
	logic [NW-1:0] link_dflt;
	logic [AW-1:0] node_raddr;

	logic          head_we;
	logic [NW-1:0] head_wdata;
	logic          link_we;
	logic [AW-1:0] link_waddr;
	logic [NW-1:0] link_wdata;
	logic          kv_we;
	logic          val_we;
	logic [AW-1:0] val_waddr;

	// The sizes in use follow from the registers; a write to either one clears the
	// table, so they never change under stored entries.
	always_comb begin
		cap_used = NW'(cap_clamp(capacity_q, NODES));
		bkt_used = 7'(bkt_clamp(bucket_count_q, cap_clamp(capacity_q, NODES), BUCKETS));
		cap_wr   = (cfg_index == CFG_CAPACITY) ? cfg_data : capacity_q;
	end

	assign busy       = (state_q != S_IDLE);
	assign cfg_ready  = !busy;
	assign cfg_we     = cfg_valid && cfg_ready;
	assign hash_start = start && !busy;

	chte_hash u_hash (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (hash_start),
		.key     (trim_bytes(key, KEY_BYTES)),
		.modulus (bkt_used),
		.done    (hash_done),
		.bucket  (hash_bucket)
	);

	// Entries that were never written since the last clear read as their reset
	// value: an empty chain, or the in-order free list.
	always_comb begin
		head_rd   = head_vld_s1 ? head_rd_s1 : NIL;
		link_dflt = ((NW'(node_raddr_s1) + NW'(1)) < cap_used) ?
			(NW'(node_raddr_s1) + NW'(1)) : NIL;
		link_rd   = link_vld_s1 ? link_rd_s1 : link_dflt;
	end

	// Read address: the free-list head while an add looks for a node, else the
	// node under visit.
	always_comb begin
		if (state_q == S_ACT && type_q == REQ_ADD) node_raddr = free_head_q[AW-1:0];
		else node_raddr = node_q[AW-1:0];
	end

	// Write ports. Every state writes each memory at most once.
	always_comb begin
		head_we    = 1'b0;
		head_wdata = free_head_q;
		link_we    = 1'b0;
		link_waddr = free_head_q[AW-1:0];
		link_wdata = head_q;
		kv_we      = 1'b0;
		val_we     = 1'b0;
		val_waddr  = free_head_q[AW-1:0];
		case (state_q)
			S_ACT: begin
				if (type_q == REQ_ADD && found_q) begin
					val_we    = 1'b1;
					val_waddr = node_q[AW-1:0];
				end
			end
			S_ALLOC: begin
				// The free-list head becomes the new chain head.
				head_we = 1'b1;
				link_we = 1'b1;
				kv_we   = 1'b1;
				val_we  = 1'b1;
			end
			S_REM1: begin
				// Unlink the node from its predecessor or from the bucket.
				if (prev_q == NIL) begin
					head_we    = 1'b1;
					head_wdata = link_q;
				end else begin
					link_we    = 1'b1;
					link_waddr = prev_q[AW-1:0];
					link_wdata = link_q;
				end
			end
			S_REM2: begin
				// Push the freed node onto the free list.
				link_we    = 1'b1;
				link_waddr = node_q[AW-1:0];
				link_wdata = free_head_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (head_we) head_mem[bucket_q] <= head_wdata;
		head_rd_s1  <= head_mem[bucket_q];
		head_vld_s1 <= head_vld_q[bucket_q];
	end

	always_ff @(posedge clk) begin
		if (kv_we) key_mem[free_head_q[AW-1:0]] <= key_q;
		if (val_we) val_mem[val_waddr] <= val_q;
		if (link_we) link_mem[link_waddr] <= link_wdata;
		key_rd_s1     <= key_mem[node_raddr];
		val_rd_s1     <= val_mem[node_raddr];
		link_rd_s1    <= link_mem[node_raddr];
		link_vld_s1   <= link_vld_q[node_raddr];
		node_raddr_s1 <= node_raddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= '0;
			link_vld_q <= '0;
		end else if (cfg_we) begin
			head_vld_q <= '0;
			link_vld_q <= '0;
		end else begin
			if (head_we) head_vld_q[bucket_q] <= 1'b1;
			if (link_we) link_vld_q[link_waddr] <= 1'b1;
		end
	end

	// Request sequencer: hash, read the chain head, walk the chain, then act.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			bucket_count_q <= 7'd64;
			capacity_q     <= 9'd256;
			free_head_q    <= '0;
			free_total_q   <= NW'(cap_clamp(9'd256, NODES));
			type_q         <= REQ_ADD;
			key_q          <= '0;
			val_q          <= '0;
			bucket_q       <= '0;
			node_q         <= NIL;
			prev_q         <= NIL;
			head_q         <= NIL;
			link_q         <= NIL;
			steps_q        <= '0;
			found_q        <= 1'b0;
			done_q         <= 1'b0;
			status_q       <= ST_OK;
			value_out_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == CFG_BUCKET_COUNT) bucket_count_q <= cfg_data[6:0];
				else capacity_q <= cfg_data;
				free_head_q  <= '0;
				free_total_q <= NW'(cap_clamp(cap_wr, NODES));
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						type_q  <= req_type;
						key_q   <= trim_bytes(key, KEY_BYTES);
						val_q   <= trim_bytes(value, VALUE_BYTES);
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (hash_done) begin
						bucket_q <= BW'(hash_bucket);
						state_q  <= S_HEAD;
					end
				end
				S_HEAD: state_q <= S_HEADW;
				S_HEADW: begin
					head_q  <= head_rd;
					node_q  <= head_rd;
					prev_q  <= NIL;
					steps_q <= '0;
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (node_q >= NIL || steps_q >= NIL) begin
						node_q  <= NIL;
						found_q <= 1'b0;
						state_q <= S_ACT;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (key_rd_s1 == key_q) begin
						link_q  <= link_rd;
						found_q <= 1'b1;
						state_q <= S_ACT;
					end else begin
						prev_q  <= node_q;
						node_q  <= link_rd;
						steps_q <= steps_q + NW'(1);
						state_q <= S_WALK;
					end
				end
				S_ACT: begin
					status_q    <= ST_NOTFOUND;
					value_out_q <= '0;
					state_q     <= S_IDLE;
					case (type_q)
						REQ_ADD: begin
							if (found_q) begin
								status_q <= ST_OK;
								done_q   <= 1'b1;
							end else if (free_total_q == '0 || free_head_q >= NIL) begin
								status_q <= ST_FULL;
								done_q   <= 1'b1;
							end else begin
								state_q <= S_ALLOC;
							end
						end
						REQ_GET: begin
							if (found_q) state_q <= S_GETW;
							else done_q <= 1'b1;
						end
						REQ_REMOVE: begin
							if (found_q) state_q <= S_REM1;
							else done_q <= 1'b1;
						end
						default: done_q <= 1'b1;
					endcase
				end
				S_ALLOC: begin
					free_head_q  <= link_rd;
					free_total_q <= free_total_q - NW'(1);
					status_q     <= ST_OK;
					done_q       <= 1'b1;
					state_q      <= S_IDLE;
				end
				S_GETW: begin
					value_out_q <= val_rd_s1;
					status_q    <= ST_OK;
					done_q      <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_REM1: state_q <= S_REM2;
				S_REM2: begin
					free_head_q  <= node_q;
					free_total_q <= free_total_q + NW'(1);
					status_q     <= ST_OK;
					done_q       <= 1'b1;
					state_q      <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign value_out  = value_out_q;
	assign free_count = 9'(free_total_q);

`ifndef SYNTHESIS
	a_free_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		free_total_q <= cap_used) else $error("free count above capacity in use");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == S_IDLE) else $error("result while busy");
	a_hash_in_hash: assert property (@(posedge clk) disable iff (!arst_n)
		hash_done |-> state_q == S_HASH) else $error("hash result outside hash phase");
	a_full_only_add: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == ST_FULL) |-> type_q == REQ_ADD)
		else $error("full status on a request that is not an add");
	a_value_only_get: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && type_q != REQ_GET) |-> value_out_q == '0)
		else $error("value out on a request that is not a get");
`endif

endmodule
`default_nettype wire

@@ design/chte_hash.sv @@
// Iterative ELF hash of a key, one byte a cycle, then a bit-serial remainder.
`timescale 1ns / 1ps
`default_nettype none
module chte_hash import chte_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] key,
	input  wire logic [6:0]  modulus,
	output logic             done,
	output logic [6:0]       bucket
);

	typedef enum logic [1:0] {H_IDLE, H_BYTES, H_MOD} hstate_t;

	localparam logic [4:0] LAST_BYTE = 5'd7;
	localparam logic [4:0] LAST_BIT  = 5'(HASH_W - 1);

	hstate_t           state_q;
	logic [63:0]       key_q;
	logic [HASH_W-1:0] h_q;
	logic [4:0]        cnt_q;
	logic [6:0]        rem_q;
	logic              done_q;

	logic [7:0]        byte_c;
	logic [31:0]       mix;
	logic [HASH_W-1:0] h_next;
	logic [7:0]        r2;
	logic [7:0]        r3;

	always_comb begin
		byte_c = key_q[63:56];
		mix    = {h_q, 4'b0000} + {24'd0, byte_c};
		// Fold the top nibble into bits 7..4 and drop it.
		h_next = mix[HASH_W-1:0] ^ {20'd0, mix[31:28], 4'b0000};
		r2     = {rem_q, h_q[HASH_W-1]};
		r3     = (r2 >= {1'b0, modulus}) ? (r2 - {1'b0, modulus}) : r2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			key_q   <= '0;
			h_q     <= '0;
			cnt_q   <= '0;
			rem_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				H_IDLE: begin
					if (start) begin
						key_q   <= key;
						h_q     <= '0;
						cnt_q   <= '0;
						rem_q   <= '0;
						state_q <= H_BYTES;
					end
				end
				H_BYTES: begin
					if (byte_c == 8'd0) begin
						cnt_q   <= '0;
						state_q <= H_MOD;
					end else begin
						h_q   <= h_next;
						key_q <= {key_q[55:0], 8'd0};
						cnt_q <= cnt_q + 5'd1;
						if (cnt_q == LAST_BYTE) begin
							cnt_q   <= '0;
							state_q <= H_MOD;
						end
					end
				end
				H_MOD: begin
					rem_q <= r3[6:0];
					h_q   <= {h_q[HASH_W-2:0], 1'b0};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == LAST_BIT) begin
						done_q  <= 1'b1;
						state_q <= H_IDLE;
					end
				end
				default: state_q <= H_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign bucket = rem_q;

`ifndef SYNTHESIS
	a_done_from_mod: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q) == H_MOD) else $error("hash done without remainder pass");
	a_rem_below_mod: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> rem_q < modulus) else $error("remainder not below modulus");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && state_q == H_IDLE) |=> state_q == H_BYTES) else $error("hash did not start");
`endif

endmodule
`default_nettype wire

@@ tb/chte_checker.sv @@
// Checker for the chained hash table engine: predicts and compares every result.
`timescale 1ns / 1ps
module chte_checker import chte_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  req_type,
	input  logic [63:0] key,
	input  logic [63:0] value,
	input  logic        done,
	input  logic [1:0]  status,
	input  logic [63:0] value_out,
	input  logic [8:0]  free_count,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_data,
	output int          fail_count,
	output int          pending,
	output int          served,
	output int          full_seen
);
	localparam int NB = 64;
	localparam int NN = 256;
	localparam logic [8:0] NIL = 9'd256;

	typedef struct packed {
		status_t     st;
		logic [63:0] val;
		logic [8:0]  free;
	} answer_t;

	answer_t     answers[$];
	logic [6:0]  bucket_reg;
	logic [8:0]  cap_reg;
	int          cap_used, bkt_used;
	logic [8:0]  head[NB];
	logic [63:0] nkey[NN];
	logic [63:0] nval[NN];
	logic [8:0]  nlink[NN];
	logic [8:0]  free_head;
	logic [8:0]  free_total;

	function automatic logic [63:0] keep_bytes(input logic [63:0] x);
		logic [63:0] r;
		logic        live;
		r = '0;
		live = 1'b1;
		for (int i = 0; i < 8; i++) begin
			if (x[63-8*i -: 8] == 8'd0) live = 1'b0;
			if (live) r[63-8*i -: 8] = x[63-8*i -: 8];
		end
		return r;
	endfunction

	function automatic logic [31:0] pjw_hash(input logic [63:0] k);
		logic [31:0] h, g;
		h = '0;
		for (int i = 0; i < 8; i++) begin
			if (k[63-8*i -: 8] == 8'd0) break;
			h = (h << 4) + k[63-8*i -: 8];
			g = h & 32'hF000_0000;
			if (g != 0) h = h ^ (g >> 24);
			h = h & ~g;
		end
		return h;
	endfunction

	// Empties every chain and rebuilds the free list in node order.
	task automatic wipe_table();
		cap_used = (cap_reg < 1) ? 1 : int'(cap_reg);
		if (cap_used > NN) cap_used = NN;
		bkt_used = (bucket_reg < 1) ? 1 : int'(bucket_reg);
		if (bkt_used > cap_used) bkt_used = cap_used;
		if (bkt_used > NB) bkt_used = NB;
		for (int i = 0; i < NB; i++) head[i] = NIL;
		for (int i = 0; i < NN; i++) nlink[i] = (i + 1 < cap_used) ? 9'(i + 1) : NIL;
		free_head = 9'd0;
		free_total = 9'(cap_used);
	endtask

	task automatic serve_request(input req_t op, input logic [63:0] k_in,
		input logic [63:0] v_in, output answer_t a);
		logic [63:0] k, v;
		int          b, steps;
		logic [8:0]  node, prev;
		k = keep_bytes(k_in);
		v = keep_bytes(v_in);
		b = int'(pjw_hash(k) % 32'(bkt_used));
		node = head[b];
		prev = NIL;
		steps = 0;
		a.st = ST_NOTFOUND;
		a.val = '0;
		while (node < NIL && steps < NN) begin
			if (nkey[node] == k) break;
			prev = node;
			node = nlink[node];
			steps++;
		end
		if (steps >= NN) node = NIL;
		if (op == REQ_ADD) begin
			if (node == NIL) begin
				if (free_total == 0 || free_head >= NIL) begin
					a.st = ST_FULL;
				end else begin
					node = free_head;
					free_head = nlink[node];
					free_total--;
					nlink[node] = head[b];
					head[b] = node;
					nkey[node] = k;
				end
			end
			if (node != NIL) begin
				nval[node] = v;
				a.st = ST_OK;
			end
		end else if (op == REQ_GET) begin
			if (node != NIL) begin
				a.val = nval[node];
				a.st = ST_OK;
			end
		end else if (op == REQ_REMOVE) begin
			if (node != NIL) begin
				if (prev == NIL) head[b] = nlink[node];
				else nlink[prev] = nlink[node];
				nlink[node] = free_head;
				free_head = node;
				free_total++;
				a.st = ST_OK;
			end
		end
		a.free = free_total;
	endtask

	always @(posedge clk or negedge arst_n) begin
		answer_t a, got;
		if (!arst_n) begin
			answers.delete();
			bucket_reg = 7'd64;
			cap_reg = 9'd256;
			wipe_table();
			fail_count <= 0;
			pending <= 0;
			served <= 0;
			full_seen <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_BUCKET_COUNT) bucket_reg = cfg_data[6:0];
				else cap_reg = cfg_data;
				wipe_table();
			end
			if (done) begin
				got = '{status, value_out, free_count};
				if (answers.size() == 0) begin
					if (fail_count < 10) $display("%0t: result with nothing expected", $time);
					fail_count <= fail_count + 1;
				end else begin
					a = answers.pop_front();
					if (got !== a) begin
						if (fail_count < 10)
							$display("%0t: mismatch exp st=%0d val=%h free=%0d got st=%0d val=%h free=%0d",
								$time, a.st, a.val, a.free, got.st, got.val, got.free);
						fail_count <= fail_count + 1;
					end
					if (a.st == ST_FULL) full_seen <= full_seen + 1;
				end
				served <= served + 1;
			end
			if (start && !busy) begin
				serve_request(req_type, key, value, a);
				answers.push_back(a);
			end
			pending <= answers.size();
		end
	end
endmodule

@@ tb/tb.sv @@
// Testbench top for the chained hash table engine: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module tb import chte_pkg::*; ();

	localparam req_t REQ_UNKNOWN = 2'd3;
	localparam int   WATCHDOG_LIMIT = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  req_type = REQ_GET;
	logic [63:0] key = '0;
	logic [63:0] value = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_index = CFG_BUCKET_COUNT;
	logic [8:0]  cfg_data = '0;
	logic        busy, done, cfg_ready;
	logic [1:0]  status;
	logic [63:0] value_out;
	logic [8:0]  free_count;
	int          fail_count, pending, served, full_seen;
	int          idle_cycles = 0;
	int          sent = 0;

	// A small key alphabet keeps chains busy with hits, updates and removes.
	logic [63:0] key_pool[16];

	always #2 clk = ~clk;

	chained_hash_table_engine DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .key(key), .value(value), .done(done),
		.status(status), .value_out(value_out), .free_count(free_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	chte_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .key(key), .value(value), .done(done),
		.status(status), .value_out(value_out), .free_count(free_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .fail_count(fail_count), .pending(pending),
		.served(served), .full_seen(full_seen)
	);

	// The watchdog restarts whenever any transfer happens on any channel.
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog expired with %0d results outstanding.", pending);
			$display("** chained_hash_table_engine: FAILED **");
			$finish;
		end
	end

	// Builds a key of random length from the pool or from raw bits. Bytes after
	// the first zero byte are sometimes left as junk so that trimming is exercised.
	function automatic logic [63:0] pick_key();
		logic [63:0] k;
		int          cut;
		if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
		k = key_pool[$urandom_range(0, 15)];
		if ($urandom_range(0, 7) == 0) begin
			cut = $urandom_range(0, 7);
			k[63-8*cut -: 8] = 8'd0;
		end
		return k;
	endfunction

	// One request transfer: drive at the falling edge, hold until busy is low at
	// a rising edge. Start stays high into the next item unless an idle gap follows.
	task automatic send(input req_t op, input logic [63:0] k, input logic [63:0] v,
		input bit may_idle);
		@(negedge clk);
		start = 1'b1;
		req_type = op;
		key = k;
		value = v;
		do @(posedge clk); while (busy);
		sent++;
		if (may_idle && $urandom_range(0, 99) < 19) begin
			@(negedge clk);
			start = 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (pending != 0 || busy) @(negedge clk);
	endtask

	// Register writes happen only with the table idle, which also clears it.
	task automatic write_reg(input logic idx, input logic [8:0] data);
		drain();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic random_phase(input int count, input bit quiet_stretch);
		int          r;
		req_t        op;
		logic [63:0] v;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			op = (r < 45) ? REQ_ADD : (r < 75) ? REQ_GET : (r < 95) ? REQ_REMOVE : REQ_UNKNOWN;
			v = {$urandom, $urandom};
			if ($urandom_range(0, 5) == 0) v[63-8*$urandom_range(0, 7) -: 8] = 8'd0;
			send(op, pick_key(), v, !(quiet_stretch && i > count / 4 && i < count * 3 / 4));
			// Once per phase the sender holds off until all results are back.
			if (i == count / 2) drain();
		end
	endtask

	initial begin
		for (int i = 0; i < 16; i++) begin
			key_pool[i] = '0;
			for (int j = 0; j < 8; j++)
				if (j <= $urandom_range(0, 7)) key_pool[i][63-8*j -: 8] = 8'($urandom_range(1, 255));
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part on the reset configuration.
		send(REQ_GET, 64'h0, 64'h0, 0);
		send(REQ_ADD, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 0);
		send(REQ_GET, 64'h0, 64'h0, 0);
		send(REQ_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0102_0304_0506_0708, 0);
		send(REQ_GET, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 0);
		send(REQ_ADD, 64'h4100_5555_5555_5555, 64'h4142_0043_4445_4647, 0);
		send(REQ_GET, 64'h4100_0000_0000_0000, 64'h0, 0);
		send(REQ_ADD, 64'h4100_0000_0000_0000, 64'h7F00_0000_0000_0000, 0);
		send(REQ_GET, 64'h41AA_0000_0000_0000, 64'h0, 0);
		send(REQ_UNKNOWN, 64'h4100_0000_0000_0000, 64'h1234, 0);
		send(REQ_REMOVE, 64'h4100_0000_0000_0000, 64'h0, 0);
		send(REQ_REMOVE, 64'h4100_0000_0000_0000, 64'h0, 0);
		send(REQ_GET, 64'h4100_0000_0000_0000, 64'h0, 0);
		send(REQ_REMOVE, 64'h0, 64'h0, 0);
		send(REQ_GET, 64'h8080_8080_8080_8080, 64'h0, 0);

		// A one-node pool in one bucket: the second new key finds the pool exhausted.
		write_reg(CFG_CAPACITY, 9'd1);
		write_reg(CFG_BUCKET_COUNT, 9'd0);
		send(REQ_ADD, 64'h6100_0000_0000_0000, 64'h11, 0);
		send(REQ_ADD, 64'h6200_0000_0000_0000, 64'h22, 0);
		send(REQ_ADD, 64'h6100_0000_0000_0000, 64'h33, 0);
		send(REQ_GET, 64'h6100_0000_0000_0000, 64'h0, 0);
		send(REQ_REMOVE, 64'h6100_0000_0000_0000, 64'h0, 0);
		send(REQ_ADD, 64'h6200_0000_0000_0000, 64'h22, 0);

		// Random phases across a spread of settings, extremes included.
		write_reg(CFG_BUCKET_COUNT, 9'd64);
		write_reg(CFG_CAPACITY, 9'd256);
		random_phase(130, 1);
		write_reg(CFG_BUCKET_COUNT, 9'd1);
		write_reg(CFG_CAPACITY, 9'd10);
		random_phase(90, 0);
		write_reg(CFG_CAPACITY, 9'd511);
		write_reg(CFG_BUCKET_COUNT, 9'd127);
		random_phase(110, 0);
		write_reg(CFG_BUCKET_COUNT, 9'd3);
		write_reg(CFG_CAPACITY, 9'd6);
		random_phase(90, 0);
		write_reg(CFG_CAPACITY, 9'd0);
		random_phase(40, 0);
		write_reg(CFG_BUCKET_COUNT, 9'h1FF);
		write_reg(CFG_CAPACITY, 9'd12);
		random_phase(80, 0);
		write_reg(CFG_BUCKET_COUNT, 9'd7);
		write_reg(CFG_CAPACITY, 9'd256);
		random_phase(90, 1);

		drain();
		repeat (100) @(negedge clk);
		$display("Sent %0d requests over eight register settings; %0d results checked,",
			sent, served);
		$display("%0d of them answered with an exhausted pool.", full_seen);
		if (fail_count == 0) begin
			$display("** chained_hash_table_engine: PASSED **");
		end else begin
			$display("%0d mismatches.", fail_count);
			$display("** chained_hash_table_engine: FAILED **");
		end
		$finish;
	end
endmodule

@@ filelist.f @@
design/chte_pkg.sv
design/chte_hash.sv
design/chained_hash_table_engine.sv
tb/chte_checker.sv
tb/tb.sv
